[rtl/jsu_pkg.sv]
// Shared types and codes for the JSON string unescaper.
// Used by the front, queue, back and top-level modules; depends on nothing.
package jsu_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_RESULTS = 6;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_ESCAPE   = 3'd1,
    MODE_HEX      = 3'd2,
    MODE_HELD     = 3'd3,
    MODE_HELD_BS  = 3'd4,
    MODE_PAIR_HEX = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_QUOTE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_UNTERM_STRING = 3'd0,
    ERR_UNTERM_ESCAPE = 3'd1,
    ERR_BAD_HEX       = 3'd2,
    ERR_BAD_LETTER    = 3'd3,
    ERR_CONTROL       = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    err_e       err;
  } res_t;

  typedef struct packed {
    logic        cp0_vld;
    logic [20:0] cp0;
    logic        cp1_vld;
    logic [20:0] cp1;
    logic        tail_vld;
    res_t        tail;
  } job_t;

endpackage

[rtl/json_string_unescape_utf8.sv]
// Top level of the JSON string unescaper: front decoder, job queue, back expander.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
//
// Feed the bytes that follow the opening quote of a JSON string, one per
// transfer, and a transfer with tuser set when the text ends. The block
// returns the decoded text as UTF-8 bytes, then one quote or error transfer
// that closes the string, after which it starts on a new string body. The
// input side takes one byte per clock while the job queue (QueueDepth jobs)
// has room. Each input byte yields zero to six output transfers, and the
// output side delivers one transfer per clock from a registered result
// buffer while m_axis_tready is high, so plain text flows at one byte per
// cycle when neither side stalls. tlast marks the last transfer caused by
// one input byte. No start-up delay after reset.
module json_string_unescape_utf8 #(
  parameter int QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  logic          q_ready, q_valid, push, pop;
  jsu_pkg::job_t push_job, head_job;
  jsu_pkg::res_t res;

  jsu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_byte_i      (s_axis_tdata),
    .end_of_input_i (s_axis_tuser),
    .q_ready_i      (q_ready),
    .push_o         (push),
    .job_o          (push_job)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast)
  );

  assign s_axis_tready = q_ready;
  assign m_axis_tdata  = {5'd0, res.err, res.data};
  assign m_axis_tuser  = res.kind;

endmodule

[rtl/jsu_front.sv]
// Front part of the unescaper: accepts body bytes and runs the escape decoder.
// Produces one job per item with results; depends on jsu_pkg.
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_input_i,
  input  logic          q_ready_i,
  output logic          push_o,
  output jsu_pkg::job_t job_o
);

  typedef struct packed {
    logic          vld;
    jsu_pkg::res_t res;
    logic          clear;
    logic          to_escape;
    logic          to_hex;
  } step_t;

  jsu_pkg::mode_e mode_q, mode_d;
  logic [11:0]    acc_q, acc_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [9:0]     held_q, held_d;

  logic          accept;
  logic [4:0]    digit;
  logic [15:0]   full;
  logic [20:0]   held_cp;
  step_t         nb;
  step_t         eb;
  jsu_pkg::job_t job;

  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic step_t normal_step(input logic [7:0] b);
    step_t s;
    s = '0;
    s.res.kind = jsu_pkg::KIND_BYTE;
    s.res.err  = jsu_pkg::ERR_UNTERM_STRING;
    if (b == 8'h22) begin
      s.vld      = 1'b1;
      s.res.kind = jsu_pkg::KIND_QUOTE;
      s.clear    = 1'b1;
    end else if (b == 8'h5C) begin
      s.to_escape = 1'b1;
    end else if (b < 8'h20) begin
      s.vld      = 1'b1;
      s.res.kind = jsu_pkg::KIND_ERROR;
      s.res.err  = jsu_pkg::ERR_CONTROL;
      s.clear    = 1'b1;
    end else begin
      s.vld      = 1'b1;
      s.res.data = b;
    end
    return s;
  endfunction

  function automatic step_t escape_step(input logic [7:0] b);
    step_t s;
    s = '0;
    s.vld      = 1'b1;
    s.res.kind = jsu_pkg::KIND_BYTE;
    s.res.err  = jsu_pkg::ERR_UNTERM_STRING;
    unique case (b)
      8'h22, 8'h5C, 8'h2F: s.res.data = b;
      8'h62: s.res.data = 8'h08;
      8'h66: s.res.data = 8'h0C;
      8'h6E: s.res.data = 8'h0A;
      8'h72: s.res.data = 8'h0D;
      8'h74: s.res.data = 8'h09;
      8'h75: begin
        s.vld    = 1'b0;
        s.to_hex = 1'b1;
      end
      default: begin
        s.res.kind = jsu_pkg::KIND_ERROR;
        s.res.err  = jsu_pkg::ERR_BAD_LETTER;
        s.clear    = 1'b1;
      end
    endcase
    return s;
  endfunction

  assign accept  = in_valid_i && q_ready_i;
  assign digit   = hex_value(in_byte_i);
  assign full    = {acc_q, digit[3:0]};
  assign held_cp = {5'd0, 6'b110110, held_q};
  assign nb      = normal_step(in_byte_i);
  assign eb      = escape_step(in_byte_i);

  always_comb begin
    logic clear;
    logic is_high;
    logic is_low;
    clear   = 1'b0;
    is_high = (full[15:10] == 6'b110110);
    is_low  = (full[15:10] == 6'b110111);
    job     = '0;
    job.tail.kind = jsu_pkg::KIND_BYTE;
    job.tail.err  = jsu_pkg::ERR_UNTERM_STRING;
    mode_d = mode_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    held_d = held_q;

    unique case (mode_q)
      jsu_pkg::MODE_ESCAPE: begin
        if (end_of_input_i) begin
          job.tail_vld  = 1'b1;
          job.tail.kind = jsu_pkg::KIND_ERROR;
          job.tail.err  = jsu_pkg::ERR_UNTERM_ESCAPE;
          clear = 1'b1;
        end else if (eb.to_hex) begin
          mode_d = jsu_pkg::MODE_HEX;
          acc_d  = '0;
          cnt_d  = '0;
        end else begin
          job.tail_vld = 1'b1;
          job.tail     = eb.res;
          mode_d       = jsu_pkg::MODE_NORMAL;
          clear        = eb.clear;
        end
      end
      jsu_pkg::MODE_HEX: begin
        if (end_of_input_i || !digit[4]) begin
          job.tail_vld  = 1'b1;
          job.tail.kind = jsu_pkg::KIND_ERROR;
          job.tail.err  = jsu_pkg::ERR_BAD_HEX;
          clear = 1'b1;
        end else if (cnt_q == 2'd3) begin
          acc_d = '0;
          cnt_d = '0;
          if (is_high) begin
            held_d = full[9:0];
            mode_d = jsu_pkg::MODE_HELD;
          end else begin
            job.cp0_vld = 1'b1;
            job.cp0     = {5'd0, full};
            mode_d      = jsu_pkg::MODE_NORMAL;
          end
        end else begin
          acc_d = full[11:0];
          cnt_d = cnt_q + 2'd1;
        end
      end
      jsu_pkg::MODE_HELD: begin
        if (end_of_input_i) begin
          job.cp0_vld   = 1'b1;
          job.cp0       = held_cp;
          job.tail_vld  = 1'b1;
          job.tail.kind = jsu_pkg::KIND_ERROR;
          job.tail.err  = jsu_pkg::ERR_UNTERM_STRING;
          clear = 1'b1;
        end else if (nb.to_escape) begin
          mode_d = jsu_pkg::MODE_HELD_BS;
        end else begin
          job.cp0_vld  = 1'b1;
          job.cp0      = held_cp;
          job.tail_vld = nb.vld;
          job.tail     = nb.res;
          mode_d       = jsu_pkg::MODE_NORMAL;
          clear        = nb.clear;
        end
      end
      jsu_pkg::MODE_HELD_BS: begin
        if (end_of_input_i) begin
          job.cp0_vld   = 1'b1;
          job.cp0       = held_cp;
          job.tail_vld  = 1'b1;
          job.tail.kind = jsu_pkg::KIND_ERROR;
          job.tail.err  = jsu_pkg::ERR_UNTERM_ESCAPE;
          clear = 1'b1;
        end else if (eb.to_hex) begin
          mode_d = jsu_pkg::MODE_PAIR_HEX;
          acc_d  = '0;
          cnt_d  = '0;
        end else begin
          job.cp0_vld  = 1'b1;
          job.cp0      = held_cp;
          job.tail_vld = 1'b1;
          job.tail     = eb.res;
          mode_d       = jsu_pkg::MODE_NORMAL;
          clear        = eb.clear;
        end
      end
      jsu_pkg::MODE_PAIR_HEX: begin
        if (end_of_input_i || !digit[4]) begin
          job.cp0_vld   = 1'b1;
          job.cp0       = held_cp;
          job.tail_vld  = 1'b1;
          job.tail.kind = jsu_pkg::KIND_ERROR;
          job.tail.err  = jsu_pkg::ERR_BAD_HEX;
          clear = 1'b1;
        end else if (cnt_q == 2'd3) begin
          acc_d       = '0;
          cnt_d       = '0;
          job.cp0_vld = 1'b1;
          if (is_low) begin
            job.cp0 = 21'h10000 + {1'b0, held_q, full[9:0]};
            clear   = 1'b1;
          end else begin
            job.cp0 = held_cp;
            if (is_high) begin
              held_d = full[9:0];
              mode_d = jsu_pkg::MODE_HELD;
            end else begin
              job.cp1_vld = 1'b1;
              job.cp1     = {5'd0, full};
              mode_d      = jsu_pkg::MODE_NORMAL;
            end
          end
        end else begin
          acc_d = full[11:0];
          cnt_d = cnt_q + 2'd1;
        end
      end
      default: begin
        if (end_of_input_i) begin
          job.tail_vld  = 1'b1;
          job.tail.kind = jsu_pkg::KIND_ERROR;
          job.tail.err  = jsu_pkg::ERR_UNTERM_STRING;
          clear = 1'b1;
        end else if (nb.to_escape) begin
          mode_d = jsu_pkg::MODE_ESCAPE;
        end else begin
          job.tail_vld = nb.vld;
          job.tail     = nb.res;
          mode_d       = jsu_pkg::MODE_NORMAL;
          clear        = nb.clear;
        end
      end
    endcase

    if (clear) begin
      mode_d = jsu_pkg::MODE_NORMAL;
      acc_d  = '0;
      cnt_d  = '0;
      held_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_NORMAL;
      acc_q  <= '0;
      cnt_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      held_q <= held_d;
    end
  end

  assign push_o = accept && (job.cp0_vld || job.cp1_vld || job.tail_vld);
  assign job_o  = job;

endmodule

[rtl/jsu_fifo.sv]
// Short job queue between the front and back parts of the unescaper.
// Holds decoded jobs in registers; depends on jsu_pkg.
module jsu_fifo #(
  parameter int Depth = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::job_t job_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output jsu_pkg::job_t job_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jsu_pkg::job_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/jsu_back.sv]
// Back part of the unescaper: expands queued jobs into UTF-8 result transfers.
// Keeps a registered result buffer that drives the output; depends on jsu_pkg.
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  jsu_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output jsu_pkg::res_t out_res_o,
  output logic          out_last_o
);

  localparam int Slots = jsu_pkg::MAX_RESULTS;
  localparam int CntW  = $clog2(Slots + 1);

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } enc_t;

  function automatic enc_t utf8_enc(input logic vld, input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (!vld) begin
      e.len = 3'd0;
    end else if (cp[20:7] == '0) begin
      e.len  = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp[20:11] == '0) begin
      e.len  = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp[20:16] == '0) begin
      e.len  = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.len  = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  jsu_pkg::res_t   buf_q [Slots];
  logic [CntW-1:0] cnt_q;
  jsu_pkg::res_t   exp_res [Slots];
  logic [CntW-1:0] exp_cnt;
  enc_t            e0, e1;
  logic            take, done, load;

  assign e0 = utf8_enc(job_i.cp0_vld, job_i.cp0);
  assign e1 = utf8_enc(job_i.cp1_vld, job_i.cp1);
  assign exp_cnt = CntW'(e0.len) + CntW'(e1.len) + CntW'(job_i.tail_vld);

  always_comb begin
    logic [2:0] k3;
    logic [2:0] idx1;
    for (int k = 0; k < Slots; k++) begin
      k3   = 3'(k);
      idx1 = k3 - e0.len;
      exp_res[k].kind = jsu_pkg::KIND_BYTE;
      exp_res[k].err  = jsu_pkg::ERR_UNTERM_STRING;
      if (k3 < e0.len) begin
        exp_res[k].data = e0.b[k3[1:0]];
      end else if (idx1 < e1.len) begin
        exp_res[k].data = e1.b[idx1[1:0]];
      end else begin
        exp_res[k] = job_i.tail;
      end
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = buf_q[0];
  assign out_last_o  = (cnt_q == CntW'(1));
  assign take        = out_valid_o && out_ready_i;
  assign done        = take && out_last_o;
  assign load        = job_valid_i && (!out_valid_o || done);
  assign pop_o       = load;

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= exp_res;
    end else if (take) begin
      for (int i = 0; i < Slots - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= exp_cnt;
    end else if (take) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

[rtl/jsu_checker.sv]
// Port-level checks for the JSON string unescaper, bound to its top level.
// Depends on jsu_pkg and json_string_unescape_utf8.
module jsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("Output transfer changed while stalled.");

  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == jsu_pkg::KIND_ERROR |-> m_axis_tlast)
    else $error("Error transfer is not the last one of its input byte.");

  a_quote_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == jsu_pkg::KIND_QUOTE |-> m_axis_tlast)
    else $error("Quote transfer is not the last one of its input byte.");

  a_code_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != jsu_pkg::KIND_ERROR |-> m_axis_tdata[10:8] == 3'd0)
    else $error("Error code set on a transfer that is not an error.");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
